@@ rtl/core/dadn_pkg.sv @@
package dadn_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffsetW = 16;
  // Running day count: day plus offset, signed, with headroom.
  localparam int unsigned DayAccW = 17;
  // Running year: may pass 16383 going forward and reach -1 going back.
  localparam int unsigned YearAccW = 16;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] DaysLeapFeb  = 5'd29;
  localparam logic [DayW-1:0] DaysFeb      = 5'd28;
  localparam logic [DayW-1:0] DaysShort    = 5'd30;
  localparam logic [DayW-1:0] DaysLong     = 5'd31;
  localparam logic [DayW-1:0] DayFirst     = 5'd1;

  localparam logic [YearW-1:0] YearMax     = 14'd9999;
  localparam logic [YearW-1:0] YearMin     = 14'd0;
  localparam logic [YearW-1:0] Cycle400    = 14'd400;
  localparam logic [YearW-1:0] Cycle100    = 14'd100;
  localparam logic [8:0]       Rem400Top   = 9'd399;
  localparam logic [6:0]       Rem100Top   = 7'd99;

  typedef struct packed {
    logic [YearW-1:0]          year_in;
    logic [MonthW-1:0]         month_in;
    logic [DayW-1:0]           day_in;
    logic signed [OffsetW-1:0] day_offset;
  } dadn_req_t;

  typedef struct packed {
    logic [YearW-1:0]  year_out;
    logic [MonthW-1:0] month_out;
    logic [DayW-1:0]   day_out;
    logic              range_error;
  } dadn_rsp_t;

  // Year position within the leap cycles, enough to decide the leap rule.
  typedef struct packed {
    logic [1:0] yr_lo;
    logic [6:0] rem100;
    logic [8:0] rem400;
  } dadn_yrpos_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_R400,
    ST_R100,
    ST_FWD,
    ST_BWD,
    ST_FIN
  } dadn_state_e;

endpackage

@@ rtl/core/dadn_month_len.sv @@
module dadn_month_len import dadn_pkg::*; (
  input  logic [MonthW-1:0] month_i,
  input  dadn_yrpos_t       pos_i,
  output logic [DayW-1:0]   len_o
);

  logic leap;

  // Divisible by 4 and not by 100, or divisible by 400.
  assign leap = ((pos_i.yr_lo == 2'd0) && (pos_i.rem100 != 7'd0)) || (pos_i.rem400 == 9'd0);

  always_comb begin
    case (month_i) inside
      MonthFeb:                               len_o = leap ? DaysLeapFeb : DaysFeb;
      MonthApr, MonthJun, MonthSep, MonthNov: len_o = DaysShort;
      default:                                len_o = DaysLong;
    endcase
  end

endmodule

@@ rtl/core/date_add_days_normalizer_unit.sv @@
// A request passes through ST_R400, ST_R100, the forward and backward month walks and ST_FIN;
// the backward walk ends early when the borrow runs below year zero.
// The month walk steps one month per cycle, forwards through one month-length unit and
// backwards through another; busy drops in the cycle the result is shown,
// so the next request can be taken in that cycle; no request is taken while busy.
// The result appears on rsp_o for one cycle with valid_o; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears valid_o.
module date_add_days_normalizer_unit import dadn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dadn_req_t req_i,
  output logic      valid_o,
  output dadn_rsp_t rsp_o
);

  dadn_state_e state_q, state_d;

  logic signed [DayAccW-1:0]  day_q, day_d;
  logic [MonthW-1:0]          month_q, month_d;
  logic signed [YearAccW-1:0] year_q, year_d;
  logic [YearW-1:0]           rem_q, rem_d;
  logic [8:0]                 rem400_q, rem400_d;
  logic [6:0]                 rem100_q, rem100_d;
  logic                       valid_q, valid_d;
  dadn_rsp_t                  rsp_q, rsp_d;

  logic                       accept;
  dadn_yrpos_t                pos_cur, pos_prev;
  logic [DayW-1:0]            len_cur, len_prev;
  logic signed [DayAccW-1:0]  len_cur_ext, len_prev_ext;
  logic [MonthW-1:0]          month_prev;
  logic                       fwd_go, bwd_go, year_wrap_back;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Position of the current year, and of the year before it for a January borrow.
  assign pos_cur.yr_lo  = year_q[1:0];
  assign pos_cur.rem100 = rem100_q;
  assign pos_cur.rem400 = rem400_q;

  assign year_wrap_back  = (month_q == MonthJan);
  assign month_prev      = year_wrap_back ? MonthDec : month_q - 4'd1;
  assign pos_prev.yr_lo  = year_wrap_back ? year_q[1:0] - 2'd1 : year_q[1:0];
  assign pos_prev.rem100 = !year_wrap_back ? rem100_q :
                           (rem100_q == 7'd0) ? Rem100Top : rem100_q - 7'd1;
  assign pos_prev.rem400 = !year_wrap_back ? rem400_q :
                           (rem400_q == 9'd0) ? Rem400Top : rem400_q - 9'd1;

  dadn_month_len u_len_cur (
    .month_i (month_q),
    .pos_i   (pos_cur),
    .len_o   (len_cur)
  );

  dadn_month_len u_len_prev (
    .month_i (month_prev),
    .pos_i   (pos_prev),
    .len_o   (len_prev)
  );

  assign len_cur_ext  = $signed({{(DayAccW-DayW){1'b0}}, len_cur});
  assign len_prev_ext = $signed({{(DayAccW-DayW){1'b0}}, len_prev});
  assign fwd_go       = (day_q > len_cur_ext);
  assign bwd_go       = (day_q <= $signed({DayAccW{1'b0}}));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_R400;
      ST_R400: if (rem_q < Cycle400) state_d = ST_R100;
      ST_R100: if (rem_q < Cycle100) state_d = ST_FWD;
      ST_FWD:  if (!fwd_go) state_d = ST_BWD;
      ST_BWD: begin
        if (!bwd_go) begin
          state_d = ST_FIN;
        end else if (year_wrap_back && (year_q == '0)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    rem_d    = rem_q;
    rem400_d = rem400_q;
    rem100_d = rem100_q;
    valid_d  = 1'b0;
    rsp_d    = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          day_d = $signed({{(DayAccW-DayW){1'b0}}, req_i.day_in})
                + {{(DayAccW-OffsetW){req_i.day_offset[OffsetW-1]}}, req_i.day_offset};
          if (req_i.month_in < MonthJan) begin
            month_d = MonthJan;
          end else if (req_i.month_in > MonthDec) begin
            month_d = MonthDec;
          end else begin
            month_d = req_i.month_in;
          end
          year_d = $signed({{(YearAccW-YearW){1'b0}}, req_i.year_in});
          rem_d  = req_i.year_in;
        end
      end
      ST_R400: begin
        if (rem_q >= Cycle400) begin
          rem_d = rem_q - Cycle400;
        end else begin
          rem400_d = rem_q[8:0];
        end
      end
      ST_R100: begin
        if (rem_q >= Cycle100) begin
          rem_d = rem_q - Cycle100;
        end else begin
          rem100_d = rem_q[6:0];
        end
      end
      ST_FWD: begin
        if (fwd_go) begin
          day_d = day_q - len_cur_ext;
          if (month_q == MonthDec) begin
            month_d  = MonthJan;
            year_d   = year_q + 16'sd1;
            rem100_d = (rem100_q == Rem100Top) ? 7'd0 : rem100_q + 7'd1;
            rem400_d = (rem400_q == Rem400Top) ? 9'd0 : rem400_q + 9'd1;
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end
      ST_BWD: begin
        if (bwd_go) begin
          month_d = month_prev;
          if (year_wrap_back) begin
            year_d   = year_q - 16'sd1;
            rem100_d = pos_prev.rem100;
            rem400_d = pos_prev.rem400;
          end
          // Going below year zero stops the walk without adding a month length.
          if (!(year_wrap_back && (year_q == '0))) begin
            day_d = day_q + len_prev_ext;
          end
        end
      end
      ST_FIN: begin
        valid_d = 1'b1;
        if (year_q < 0) begin
          rsp_d.year_out    = YearMin;
          rsp_d.month_out   = MonthJan;
          rsp_d.day_out     = DayFirst;
          rsp_d.range_error = 1'b1;
        end else if (year_q > $signed({{(YearAccW-YearW){1'b0}}, YearMax})) begin
          rsp_d.year_out    = YearMax;
          rsp_d.month_out   = MonthDec;
          rsp_d.day_out     = DaysLong;
          rsp_d.range_error = 1'b1;
        end else begin
          rsp_d.year_out    = year_q[YearW-1:0];
          rsp_d.month_out   = month_q;
          rsp_d.day_out     = day_q[DayW-1:0];
          rsp_d.range_error = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q    <= day_d;
    month_q  <= month_d;
    year_q   <= year_d;
    rem_q    <= rem_d;
    rem400_q <= rem400_d;
    rem100_q <= rem100_d;
    rsp_q    <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

@@ verif/tb.sv @@
module tb;
  import dadn_pkg::*;

  localparam int unsigned PhaseRequests = 180;
  localparam int unsigned DrainCycles   = 40;

  typedef struct {
    dadn_req_t req;
    bit        fixed;
    dadn_rsp_t rsp;
  } date_case_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  dadn_req_t req_i  = '0;
  logic      busy;
  logic      valid_o;
  dadn_rsp_t rsp_o;

  dadn_rsp_t  pending_dates[$];
  date_case_t directed_cases[$];
  int unsigned n_requests = 0;
  int unsigned n_results  = 0;
  int unsigned n_clamped  = 0;
  int unsigned n_failures = 0;

  date_add_days_normalizer_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(int m, int y);
    if (m == int'(MonthFeb)) return is_leap(y) ? int'(DaysLeapFeb) : int'(DaysFeb);
    if (m == int'(MonthApr) || m == int'(MonthJun) || m == int'(MonthSep) ||
        m == int'(MonthNov)) return int'(DaysShort);
    return int'(DaysLong);
  endfunction

  // Walks the day count month by month, forwards first and then backwards.
  function automatic dadn_rsp_t normalize_date(dadn_req_t r);
    int yr;
    int mon;
    int dd;
    dadn_rsp_t res;
    yr  = int'(r.year_in);
    mon = int'(r.month_in);
    dd  = int'(r.day_in) + int'($signed(r.day_offset));
    res = '0;
    if (mon < int'(MonthJan)) mon = int'(MonthJan);
    if (mon > int'(MonthDec)) mon = int'(MonthDec);
    while (dd > days_in_month(mon, yr)) begin
      dd -= days_in_month(mon, yr);
      mon++;
      if (mon > int'(MonthDec)) begin
        mon = int'(MonthJan);
        yr++;
      end
    end
    while (dd <= 0) begin
      mon--;
      if (mon < int'(MonthJan)) begin
        mon = int'(MonthDec);
        yr--;
        if (yr < 0) break;
      end
      dd += days_in_month(mon, yr);
    end
    if (yr < 0) begin
      res.year_out    = YearMin;
      res.month_out   = MonthJan;
      res.day_out     = DayFirst;
      res.range_error = 1'b1;
    end else if (yr > int'(YearMax)) begin
      res.year_out    = YearMax;
      res.month_out   = MonthDec;
      res.day_out     = DaysLong;
      res.range_error = 1'b1;
    end else begin
      res.year_out  = yr[YearW-1:0];
      res.month_out = mon[MonthW-1:0];
      res.day_out   = dd[DayW-1:0];
    end
    return res;
  endfunction

  function automatic date_case_t date_case(int y, int m, int d, int off, bit fixed,
                                           int ey = 0, int em = 0, int ed = 0, bit ee = 0);
    date_case_t c;
    c.req.year_in     = y[YearW-1:0];
    c.req.month_in    = m[MonthW-1:0];
    c.req.day_in      = d[DayW-1:0];
    c.req.day_offset  = off[OffsetW-1:0];
    c.fixed           = fixed;
    c.rsp.year_out    = ey[YearW-1:0];
    c.rsp.month_out   = em[MonthW-1:0];
    c.rsp.day_out     = ed[DayW-1:0];
    c.rsp.range_error = ee;
    return c;
  endfunction

  // Start stays high from one request to the next unless the sender idles in between.
  task automatic issue_request(input dadn_req_t r, input bit use_fixed,
                               input dadn_rsp_t fixed_rsp, input int unsigned idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_dates.push_back(use_fixed ? fixed_rsp : normalize_date(r));
    n_requests++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    dadn_rsp_t want;
    if (rst_ni && valid_o) begin
      n_results++;
      if (rsp_o.range_error === 1'b1) n_clamped++;
      if (pending_dates.size() == 0) begin
        $error("result with no request outstanding: %0d-%0d-%0d err %0b",
               rsp_o.year_out, rsp_o.month_out, rsp_o.day_out, rsp_o.range_error);
        n_failures++;
      end else begin
        want = pending_dates.pop_front();
        if (rsp_o.year_out !== want.year_out) begin
          $error("year_out: expected %0d, got %0d", want.year_out, rsp_o.year_out);
          n_failures++;
        end
        if (rsp_o.month_out !== want.month_out) begin
          $error("month_out: expected %0d, got %0d", want.month_out, rsp_o.month_out);
          n_failures++;
        end
        if (rsp_o.day_out !== want.day_out) begin
          $error("day_out: expected %0d, got %0d", want.day_out, rsp_o.day_out);
          n_failures++;
        end
        if (rsp_o.range_error !== want.range_error) begin
          $error("range_error: expected %0b, got %0b", want.range_error, rsp_o.range_error);
          n_failures++;
        end
      end
    end
  end

  initial begin
    dadn_req_t   rq;
    int unsigned pick;
    int          off;
    int unsigned idle_pct;
    directed_cases = '{
      date_case(2024, 1, 15, 0, 1, 2024, 1, 15, 0),
      date_case(2023, 12, 31, 1, 1, 2024, 1, 1, 0),
      date_case(2024, 3, 1, -1, 1, 2024, 2, 29, 0),
      date_case(2023, 3, 1, -1, 1, 2023, 2, 28, 0),
      date_case(1900, 3, 1, -1, 1, 1900, 2, 28, 0),
      date_case(2000, 3, 1, -1, 1, 2000, 2, 29, 0),
      date_case(2100, 2, 28, 1, 1, 2100, 3, 1, 0),
      date_case(0, 3, 1, -1, 1, 0, 2, 29, 0),
      date_case(0, 1, 1, -1, 1, 0, 1, 1, 1),
      date_case(0, 1, 1, -32768, 1, 0, 1, 1, 1),
      date_case(9999, 12, 31, 1, 1, 9999, 12, 31, 1),
      date_case(9999, 6, 15, 32767, 1, 9999, 12, 31, 1),
      date_case(2021, 0, 10, 0, 1, 2021, 1, 10, 0),
      date_case(2021, 15, 10, 0, 1, 2021, 12, 10, 0),
      date_case(2021, 3, 0, 0, 1, 2021, 2, 28, 0),
      date_case(2021, 4, 31, 0, 1, 2021, 5, 1, 0),
      date_case(16383, 15, 31, -1, 1, 9999, 12, 31, 1),
      date_case(16383, 1, 1, -32768, 1, 9999, 12, 31, 1),
      date_case(10050, 1, 1, -32768, 0),
      date_case(0, 12, 31, 32767, 0),
      date_case(2024, 2, 29, 365, 0),
      date_case(10922, 10, 21, 21845, 0),
      date_case(5461, 5, 10, -21846, 0),
      date_case(9999, 12, 31, -32768, 0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cases[i])
      issue_request(directed_cases[i].req, directed_cases[i].fixed, directed_cases[i].rsp, 0);
    wait_drained();

    // Sender idles less, then more, then not at all.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 26 : (ph == 1) ? 48 : 0;
      for (int n = 0; n < PhaseRequests; n++) begin
        pick = $urandom_range(99);
        if (pick < 80)      rq.year_in = YearW'($urandom_range(9999));
        else if (pick < 85) rq.year_in = YearW'($urandom_range(120));
        else if (pick < 90) rq.year_in = YearW'(9880 + $urandom_range(119));
        else                rq.year_in = YearW'($urandom_range(16383));
        rq.month_in = ($urandom_range(9) == 0) ? MonthW'($urandom_range(15))
                                               : MonthW'(1 + $urandom_range(11));
        rq.day_in = DayW'($urandom_range(31));
        // Long offsets make the month walk slow, so most requests keep them short.
        pick = $urandom_range(99);
        if (pick < 40)      off = int'($urandom_range(800)) - 400;
        else if (pick < 70) off = int'($urandom_range(8000)) - 4000;
        else                off = int'($urandom_range(65535)) - 32768;
        rq.day_offset = off[OffsetW-1:0];
        issue_request(rq, 1'b0, '0, idle_pct);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d dates with offsets across both directions and the year limits,",
             n_requests);
    $display("checked %0d normalised results, %0d of them clamped.", n_results, n_clamped);
    if (n_failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
